FILE: hw/rtl/btc_pkg.sv
// Shared types, constants and helpers of the blank-run to tab compressor.
// Depends on nothing; every other file of the block imports it.
package btc_pkg;

    localparam int MAX_RUN     = 64;
    localparam int FLUSH_LIMIT = 19;
    localparam int RUN_W       = $clog2(MAX_RUN + 1);
    localparam int TW_W        = 5;
    localparam int COL_W       = 4;
    localparam int CNT_W       = RUN_W;
    localparam int CH_W        = 8;
    localparam int CMP_W       = (RUN_W > TW_W) ? RUN_W : TW_W;
    localparam int FIFO_DEPTH  = 2;
    localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [TW_W-1:0] WIDTH_RESET = 5'd4;
    localparam logic [TW_W-1:0] WIDTH_MAX   = 5'd16;
    localparam logic [TW_W-1:0] WIDTH_MIN   = 5'd1;

    localparam logic [CH_W-1:0] CH_BLANK   = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;

    // Flush job handed from the front to the back.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [RUN_W-1:0] run;
        logic [CH_W-1:0]  ch;
        logic             with_char;
    } cmd_t;

    // Running tally of a pending blank run: end column, spaces since the
    // last stop, and characters its flush would take.
    typedef struct packed {
        logic [COL_W-1:0] e;
        logic [COL_W-1:0] r;
        logic [CNT_W-1:0] cnt;
    } trk_t;

    function automatic logic [TW_W-1:0] eff_width(input logic [TW_W-1:0] tw);
        logic [TW_W-1:0] w;
        if (tw == '0)
            w = WIDTH_MIN;
        else if (tw > WIDTH_MAX)
            w = WIDTH_MAX;
        else
            w = tw;
        return w;
    endfunction

    // Extend the tally by one blank.
    function automatic trk_t trk_add(input trk_t t, input logic [TW_W-1:0] w);
        trk_t            n;
        logic [TW_W-1:0] e_plus;
        e_plus = {1'b0, t.e} + TW_W'(1);
        if (e_plus == w)
        begin
            n.e   = '0;
            n.r   = '0;
            n.cnt = t.cnt - CNT_W'(t.r) + CNT_W'(1);
        end
        else
        begin
            n.e   = e_plus[COL_W-1:0];
            n.r   = t.r + COL_W'(1);
            n.cnt = t.cnt + CNT_W'(1);
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/btc_if.sv
// Channel interfaces of the compressor: input byte, result and width write.
// Depends on btc_pkg.
interface btc_in_if;
    import btc_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_char;
    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface btc_out_if;
    import btc_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_char;
    logic            last;
    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

interface btc_cfg_if;
    import btc_pkg::*;
    logic            valid;
    logic            ready;
    logic [TW_W-1:0] tab_width;
    modport source (output valid, output tab_width, input ready);
    modport sink   (input valid, input tab_width, output ready);
endinterface

FILE: hw/rtl/btc_front.sv
// Front end: accept bytes, track the pending blank run and issue flush jobs.
// Depends on btc_pkg and btc_in_if.
module btc_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    btc_in_if.sink                    din,
    input  logic                      cfg_wr,
    input  logic [btc_pkg::TW_W-1:0]  width,
    input  logic                      q_full,
    output logic                      push,
    output btc_pkg::cmd_t             push_cmd
);
    import btc_pkg::*;

    typedef enum logic [2:0]
    {
        ST_RUN    = 3'b001,
        ST_REDUCE = 3'b010,
        ST_REPLAY = 3'b100
    } fst_t;

    fst_t             state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] cur_reg, cur_next;
    logic [RUN_W-1:0] run_reg, run_next;
    trk_t             trk_reg, trk_next;
    logic [TW_W-1:0]  red_reg, red_next;
    logic [RUN_W-1:0] idx_reg, idx_next;

    logic             take;
    trk_t             inc;
    trk_t             fresh;
    logic [RUN_W:0]   n_plus;
    logic [TW_W-1:0]  e_plus;
    logic [COL_W-1:0] newc;

    assign din.ready = (state_reg == ST_RUN) && !q_full && !cfg_wr;
    assign take      = din.valid && din.ready;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        cur_next   = cur_reg;
        run_next   = run_reg;
        trk_next   = trk_reg;
        red_next   = red_reg;
        idx_next   = idx_reg;
        push       = 1'b0;
        push_cmd   = '{col: cur_reg, run: run_reg, ch: din.in_char, with_char: 1'b1};
        inc        = trk_add(trk_reg, width);
        fresh      = '{e: trk_reg.e, r: '0, cnt: '0};
        n_plus     = {1'b0, run_reg} + (RUN_W+1)'(1);
        e_plus     = {1'b0, trk_reg.e} + TW_W'(1);
        newc       = (e_plus == width) ? '0 : e_plus[COL_W-1:0];

        unique case (state_reg)
            ST_RUN:
            begin
                if (take)
                begin
                    if (din.in_char == CH_BLANK)
                    begin
                        if (n_plus > (RUN_W+1)'(MAX_RUN) || inc.cnt > CNT_W'(FLUSH_LIMIT))
                        begin
                            // run full or its flush too long: flush it and start over with this blank
                            push               = 1'b1;
                            push_cmd.with_char = 1'b0;
                            col_next           = trk_reg.e;
                            cur_next           = trk_reg.e;
                            run_next           = RUN_W'(1);
                            trk_next           = trk_add(fresh, width);
                        end
                        else
                        begin
                            col_next = cur_reg;
                            run_next = n_plus[RUN_W-1:0];
                            trk_next = inc;
                        end
                    end
                    else
                    begin
                        push = 1'b1;
                        if (din.in_char == CH_TAB || din.in_char == CH_NEWLINE)
                            newc = '0;
                        col_next = newc;
                        cur_next = newc;
                        run_next = '0;
                        trk_next = '{e: newc, r: '0, cnt: '0};
                    end
                end
            end
            ST_REDUCE:
            begin
                // column modulo the new width, one subtraction a cycle
                if (red_reg >= width)
                    red_next = red_reg - width;
                else
                begin
                    cur_next   = red_reg[COL_W-1:0];
                    trk_next   = '{e: red_reg[COL_W-1:0], r: '0, cnt: '0};
                    idx_next   = '0;
                    state_next = ST_REPLAY;
                end
            end
            ST_REPLAY:
            begin
                // rebuild the run tally one blank a cycle
                if (idx_reg == run_reg)
                    state_next = ST_RUN;
                else
                begin
                    trk_next = inc;
                    idx_next = idx_reg + RUN_W'(1);
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (cfg_wr)
        begin
            state_next = ST_REDUCE;
            red_next   = {1'b0, col_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            col_reg   <= '0;
            cur_reg   <= '0;
            run_reg   <= '0;
            trk_reg   <= '0;
            red_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            cur_reg   <= cur_next;
            run_reg   <= run_next;
            trk_reg   <= trk_next;
            red_reg   <= red_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: hw/rtl/btc_cmd_fifo.sv
// Short queue of flush jobs between front and back.
// Depends on btc_pkg.
module btc_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  btc_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output btc_pkg::cmd_t head
);
    import btc_pkg::*;

    cmd_t              mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + FCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - FCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/btc_back.sv
// Back end: expand each flush job into tabs and spaces, one byte a cycle while the output is not stalled.
// Depends on btc_pkg and btc_out_if.
module btc_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [btc_pkg::TW_W-1:0] width,
    input  logic                     head_valid,
    input  btc_pkg::cmd_t            head,
    output logic                     pop,
    btc_out_if.source                dout
);
    import btc_pkg::*;

    cmd_t            wk_reg, wk_next;
    logic            wk_busy_reg, wk_busy_next;
    logic            out_valid_reg, out_valid_next;
    logic [CH_W-1:0] out_char_reg, out_char_next;
    logic            out_last_reg, out_last_next;

    cmd_t             src;
    logic             src_valid;
    logic             slot_free;
    logic [TW_W-1:0]  stop_gap;
    logic [TW_W-1:0]  c_plus;
    logic [CH_W-1:0]  tok;
    logic [RUN_W-1:0] rem;
    logic [COL_W-1:0] col_n;
    logic             done;
    logic             emit;
    logic             adv;

    assign dout.valid    = out_valid_reg;
    assign dout.out_char = out_char_reg;
    assign dout.last     = out_last_reg;

    always_comb
    begin
        src       = wk_busy_reg ? wk_reg : head;
        src_valid = wk_busy_reg || head_valid;
        slot_free = !out_valid_reg || dout.ready;
        stop_gap  = width - {1'b0, src.col};
        c_plus    = {1'b0, src.col} + TW_W'(1);

        if (src.run != '0)
        begin
            if (stop_gap > TW_W'(1) && CMP_W'(stop_gap) <= CMP_W'(src.run))
            begin
                tok   = CH_TAB;
                rem   = src.run - RUN_W'(stop_gap);
                col_n = '0;
            end
            else
            begin
                tok   = CH_BLANK;
                rem   = src.run - RUN_W'(1);
                col_n = (c_plus == width) ? '0 : c_plus[COL_W-1:0];
            end
            done = (rem == '0) && !src.with_char;
            emit = 1'b1;
        end
        else
        begin
            tok   = src.ch;
            rem   = '0;
            col_n = src.col;
            done  = 1'b1;
            emit  = src.with_char;
        end

        adv = src_valid && (slot_free || !emit);
        pop = adv && !wk_busy_reg;

        wk_next        = wk_reg;
        wk_busy_next   = wk_busy_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (slot_free)
            out_valid_next = 1'b0;
        if (adv)
        begin
            wk_next      = '{col: col_n, run: rem, ch: src.ch, with_char: src.with_char};
            wk_busy_next = !done;
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_char_next  = tok;
                out_last_next  = done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wk_reg       <= wk_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wk_busy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wk_busy_reg   <= wk_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/blank_run_to_tab_compressor.sv
// Top level of the blank-run to tab compressor: width register, front, queue, back.
// Depends on btc_pkg, btc_if, btc_front, btc_cmd_fifo and btc_back.
//
//  channel | modport | payload             | transaction
//  --------+---------+---------------------+----------------------------------
//  din     | sink    | in_char[7:0]        | one text byte
//  dout    | source  | out_char[7:0], last | one emitted byte, last per flush job
//  cfg     | sink    | tab_width[4:0]      | write of the tab width register
//
// The front accepts one byte a cycle while the two-entry job queue has room and the
// front is in its run state, not rebuilding its tally after a width write.
// The back gives one result per cycle from the output register while dout is not
// stalled; the front runs on until the queue fills.
// After a tab_width write the front rebuilds its run tally and holds din.ready low
// meanwhile (reduction of the column, then one blank a cycle).
// Reset is asynchronous: width 4, column 0, no pending run, queue and output empty.
module blank_run_to_tab_compressor
(
    input  logic      clk,
    input  logic      rst_n,
    btc_in_if.sink    din,
    btc_out_if.source dout,
    btc_cfg_if.sink   cfg
);
    import btc_pkg::*;

    logic [TW_W-1:0] tab_width_reg;
    logic [TW_W-1:0] width;
    logic            cfg_wr;
    logic            push;
    cmd_t            push_cmd;
    logic            q_full;
    logic            pop;
    logic            head_valid;
    cmd_t            head;

    // Width writes are always taken; only legal while the block is idle.
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    // Clamp the register to 1..16 once, for both halves.
    assign width     = eff_width(tab_width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tab_width_reg <= WIDTH_RESET;
        else if (cfg_wr)
            tab_width_reg <= cfg.tab_width;
    end

    // Front: classify bytes, count blanks, decide when a run must be flushed.
    btc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (din),
        .cfg_wr   (cfg_wr),
        .width    (width),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue: decouple the front from back-end stalls.
    btc_cmd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back: expand jobs into tabs, spaces and the passed byte.
    btc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .width      (width),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .dout       (dout)
    );

    // A width write must hold off input while the tally is rebuilt.
    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !din.ready)
        else $error("input accepted straight after a width write");

    // The front never issues a job into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("flush job pushed into full queue");

    // A flushed run never exceeds the run limit.
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_cmd.run <= RUN_W'(MAX_RUN)))
        else $error("flush run longer than the limit");

    // The back only takes jobs that exist.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job taken from empty queue");

endmodule
